[src/rtce_pkg.sv]
// shared types and constants of the range to ternary chunk encoder
// used by every module of the block and by its checker; no dependencies

package rtce_pkg;

    // fixed port field widths
    localparam int KEY_WIDTH     = 16;
    localparam int PATTERN_WIDTH = 24;
    localparam int S_TDATA_WIDTH = 2 * KEY_WIDTH;
    localparam int M_TDATA_WIDTH = 2 * KEY_WIDTH + 2 * PATTERN_WIDTH;

    // defaults for the top level parameters
    localparam int DEF_CHUNK_BITS  = 2;
    localparam int DEF_KEY_BITS    = 16;
    localparam int DEF_QUEUE_DEPTH = 2;

    // chunk counts and positions, wide enough for one-bit chunks on a 16-bit key
    localparam int CNT_WIDTH = 5;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;

    typedef enum logic {
        RANGE_WHOLE,
        RANGE_SPLIT
    } range_kind_t;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

    // one classified range request, as queued between front and walker
    typedef struct packed {
        key_t        lo;
        key_t        hi;
        range_kind_t kind;
        cnt_t        pos_k;   // chunks below the highest differing chunk
        cnt_t        span;    // chunks covered by the first piece
    } item_t;

endpackage

[src/rtce_front.sv]
// front end: masks the incoming range, drops empty ranges and classifies the rest
// depends on rtce_pkg

module rtce_front
    import rtce_pkg::*;
#(
    parameter int CHUNK_BITS = DEF_CHUNK_BITS,
    parameter int KEY_BITS   = DEF_KEY_BITS
)(
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,
    output logic                     push_valid,
    input  logic                     push_ready,
    output item_t                    push_item
);

    localparam int NUM_CHUNKS = (KEY_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int W          = NUM_CHUNKS * CHUNK_BITS;
    localparam int CHUNK_MAX  = (1 << CHUNK_BITS) - 1;

    typedef logic [W-1:0] word_t;

    function automatic logic [CHUNK_BITS-1:0] chunk_of(input word_t v, input int idx);
        return v[idx*CHUNK_BITS +: CHUNK_BITS];
    endfunction

    function automatic word_t low_mask(input cnt_t n);
        word_t ones;
        ones = '1;
        return ~(ones << (int'(n) * CHUNK_BITS));
    endfunction

    word_t lo_w;
    word_t hi_w;
    word_t span_mask;
    logic  empty_range;
    logic  diff_found;
    cnt_t  diff_pos;
    cnt_t  zero_run;
    cnt_t  first_span;
    logic  whole;

    always_comb
    begin
        lo_w        = W'(s_tdata[KEY_BITS-1:0]);
        hi_w        = W'(s_tdata[KEY_WIDTH +: KEY_BITS]);
        empty_range = lo_w > hi_w;

        // highest chunk where the two ends differ
        diff_found = 1'b0;
        diff_pos   = '0;
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            if (chunk_of(lo_w, i) != chunk_of(hi_w, i))
            begin
                diff_found = 1'b1;
                diff_pos   = cnt_t'(i);
            end
        end

        // trailing zero chunks of the low end
        zero_run = cnt_t'(NUM_CHUNKS);
        for (int i = NUM_CHUNKS - 1; i >= 0; i--)
        begin
            if (chunk_of(lo_w, i) != '0)
                zero_run = cnt_t'(i);
        end

        span_mask = low_mask(diff_pos);
        whole     = !diff_found ||
                    (((lo_w & span_mask) == '0) && ((hi_w & span_mask) == span_mask));

        // first left-tail piece: stops one chunk lower when that chunk is already full
        if (zero_run >= diff_pos)
            first_span = diff_pos;
        else if (chunk_of(lo_w, int'(zero_run)) == CHUNK_BITS'(CHUNK_MAX))
            first_span = zero_run;
        else
            first_span = zero_run + 1'b1;
    end

    assign s_tready       = push_ready;
    assign push_valid     = s_tvalid && !empty_range;
    assign push_item.lo   = KEY_WIDTH'(lo_w);
    assign push_item.hi   = KEY_WIDTH'(hi_w);
    assign push_item.kind = whole ? RANGE_WHOLE : RANGE_SPLIT;
    assign push_item.pos_k = diff_pos;
    assign push_item.span = first_span;

endmodule

[src/rtce_queue.sv]
// short request queue between the front end and the walker
// depends on rtce_pkg for the queued item type

module rtce_queue
    import rtce_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_item;
    end

endmodule

[src/rtce_walker.sv]
// back end: walks one queued range into ascending chunk-aligned pieces
// and presents each piece with its ternary pattern; depends on rtce_pkg

module rtce_walker
    import rtce_pkg::*;
#(
    parameter int CHUNK_BITS = DEF_CHUNK_BITS,
    parameter int KEY_BITS   = DEF_KEY_BITS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  item_t                    pop_item,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata,
    output logic                     m_tlast
);

    localparam int NUM_CHUNKS = (KEY_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int W          = NUM_CHUNKS * CHUNK_BITS;
    localparam int CHUNK_MAX  = (1 << CHUNK_BITS) - 1;

    typedef logic [W-1:0] word_t;

    function automatic logic [CHUNK_BITS-1:0] chunk_of(input word_t v, input int idx);
        return v[idx*CHUNK_BITS +: CHUNK_BITS];
    endfunction

    function automatic word_t low_mask(input cnt_t n);
        word_t ones;
        ones = '1;
        return ~(ones << (int'(n) * CHUNK_BITS));
    endfunction

    // chunk [a, b]: symbol q from the right is 1 below a, 0 at or above b, else wildcard
    function automatic logic [PATTERN_WIDTH-1:0] pattern_of(input word_t lo, input word_t hi,
                                                           input logic want_care);
        logic [PATTERN_WIDTH-1:0] bits;
        int                       a;
        int                       b;
        bits = '0;
        for (int j = 0; j < NUM_CHUNKS; j++)
        begin
            a = int'(chunk_of(lo, j));
            b = int'(chunk_of(hi, j));
            for (int q = 0; q < CHUNK_MAX; q++)
            begin
                if (want_care)
                    bits[j*CHUNK_MAX + q] = (q < a) || (q >= b);
                else
                    bits[j*CHUNK_MAX + q] = q < a;
            end
        end
        return bits;
    endfunction

    walk_state_t state_reg, state_next;
    logic        first_reg, first_next;
    logic        out_valid_reg, out_valid_next;
    range_kind_t kind_reg, kind_next;
    cnt_t        pos_k_reg, pos_k_next;
    cnt_t        span_reg, span_next;
    word_t       cursor_reg, cursor_next;
    word_t       limit_reg, limit_next;
    word_t       out_low_reg, out_low_next;
    word_t       out_high_reg, out_high_next;
    logic        out_last_reg, out_last_next;

    logic  advance;
    logic  load_piece;
    logic  take_item;
    logic  diff_found;
    cnt_t  diff_pos;
    cnt_t  zero_run;
    cnt_t  block_span;
    word_t diff_mask;
    word_t piece_end;
    logic  piece_last;

    assign advance   = !out_valid_reg || m_tready;
    assign take_item = pop_valid && pop_ready;

    // next piece from the cursor
    always_comb
    begin
        diff_found = 1'b0;
        diff_pos   = '0;
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            if (chunk_of(cursor_reg, i) != chunk_of(limit_reg, i))
            begin
                diff_found = 1'b1;
                diff_pos   = cnt_t'(i);
            end
        end

        zero_run = cnt_t'(NUM_CHUNKS);
        for (int i = NUM_CHUNKS - 1; i >= 0; i--)
        begin
            if (chunk_of(cursor_reg, i) != '0)
                zero_run = cnt_t'(i);
        end

        block_span = (zero_run < pos_k_reg) ? zero_run : pos_k_reg;
        diff_mask  = low_mask(diff_pos);

        if (first_reg)
        begin
            piece_end = (kind_reg == RANGE_WHOLE) ? limit_reg
                                                  : (cursor_reg | low_mask(span_reg));
        end
        else if (!diff_found || (diff_pos < pos_k_reg))
        begin
            // right tail: close out when the rest of the high end is full
            if (!diff_found || ((limit_reg & diff_mask) == diff_mask))
                piece_end = limit_reg;
            else
                piece_end = cursor_reg | diff_mask;
        end
        else
        begin
            // left tail and middle: one aligned block per piece
            piece_end = cursor_reg | low_mask(block_span);
        end

        piece_last = piece_end == limit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WALK_IDLE:
            begin
                if (pop_valid)
                    state_next = WALK_RUN;
            end
            WALK_RUN:
            begin
                if (advance && piece_last)
                    state_next = WALK_IDLE;
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready  = 1'b0;
        load_piece = 1'b0;
        case (state_reg)
            WALK_IDLE:
            begin
                pop_ready = 1'b1;
            end
            WALK_RUN:
            begin
                load_piece = advance;
            end
            default:
            begin
                pop_ready  = 1'b0;
                load_piece = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        pos_k_next     = pos_k_reg;
        span_next      = span_reg;
        cursor_next    = cursor_reg;
        limit_next     = limit_reg;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        out_last_next  = out_last_reg;

        if (take_item)
        begin
            first_next  = 1'b1;
            kind_next   = pop_item.kind;
            pos_k_next  = pop_item.pos_k;
            span_next   = pop_item.span;
            cursor_next = W'(pop_item.lo);
            limit_next  = W'(pop_item.hi);
        end

        if (load_piece)
        begin
            first_next     = 1'b0;
            out_valid_next = 1'b1;
            cursor_next    = piece_end + 1'b1;
            out_low_next   = cursor_reg;
            out_high_next  = piece_end;
            out_last_next  = piece_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WALK_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pos_k_reg    <= pos_k_next;
        span_reg     <= span_next;
        cursor_reg   <= cursor_next;
        limit_reg    <= limit_next;
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {pattern_of(out_low_reg, out_high_reg, 1'b1),
                       pattern_of(out_low_reg, out_high_reg, 1'b0),
                       KEY_WIDTH'(out_high_reg),
                       KEY_WIDTH'(out_low_reg)};

endmodule

[src/range_to_ternary_chunk_encoder.sv]
// a taken request is held in the queue, then in the walker's range registers, and its first
// piece in the output register that drives m_tdata; throughput: one piece per cycle while
//   m_tready holds; the walker loads each range before it steps out the range's pieces,
//   and an empty range is dropped before the queue and never reaches the walker
// the walker's single piece step sets the rate; a queue lets the front take new ranges
// reset: asynchronous, active low, empties the queue, idles the walker, drops m_tvalid

module range_to_ternary_chunk_encoder
    import rtce_pkg::*;
#(
    parameter int CHUNK_BITS  = DEF_CHUNK_BITS,   // 1 or 2
    parameter int KEY_BITS    = DEF_KEY_BITS,     // 4 to 16
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH   // 2 or more
)(
    input  logic                     clk,
    input  logic                     rst_n,
    // range request
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,    // range_low [15:0], range_high [31:16]
    // piece result
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata,    // piece_low [15:0], piece_high [31:16],
                                                 // match_bits [55:32], care_bits [79:56]
    output logic                     m_tlast     // last_piece
);

    // classified requests on their way to the walker
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // front: key masking, empty-range drop, split point and first piece span
    rtce_front #(
        .CHUNK_BITS (CHUNK_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decouples request intake from the piece walk
    rtce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back: one piece per step into the output register, pattern built from it
    rtce_walker #(
        .CHUNK_BITS (CHUNK_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[src/rtce_checker.sv]
// port-level checks for the range to ternary chunk encoder, bound to the top level
// depends on rtce_pkg and on range_to_ternary_chunk_encoder

module rtce_checker
    import rtce_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [S_TDATA_WIDTH-1:0] s_tdata,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_WIDTH-1:0] m_tdata,
    input logic                     m_tlast
);

    logic exp_valid_reg, exp_valid_next;
    key_t exp_low_reg, exp_low_next;
    logic piece_taken;
    key_t piece_low;
    key_t piece_high;
    logic [PATTERN_WIDTH-1:0] match_bits;
    logic [PATTERN_WIDTH-1:0] care_bits;

    assign piece_taken = m_tvalid && m_tready;
    assign piece_low   = m_tdata[KEY_WIDTH-1:0];
    assign piece_high  = m_tdata[2*KEY_WIDTH-1:KEY_WIDTH];
    assign match_bits  = m_tdata[2*KEY_WIDTH +: PATTERN_WIDTH];
    assign care_bits   = m_tdata[2*KEY_WIDTH+PATTERN_WIDTH +: PATTERN_WIDTH];

    // expected start of the next piece within the same range
    always_comb
    begin
        exp_valid_next = exp_valid_reg;
        exp_low_next   = exp_low_reg;
        if (piece_taken)
        begin
            exp_valid_next = !m_tlast;
            exp_low_next   = piece_high + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_valid_reg <= 1'b0;
            exp_low_reg   <= '0;
        end
        else
        begin
            exp_valid_reg <= exp_valid_next;
            exp_low_reg   <= exp_low_next;
        end
    end

    // a stalled piece holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("piece changed while stalled");

    // a piece never ends below its own start
    a_piece_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> piece_low <= piece_high)
        else $error("piece low above piece high");

    // each piece of a range starts right after the previous one, without gaps or overlap
    a_piece_contig: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && exp_valid_reg |-> piece_low == exp_low_reg)
        else $error("piece does not follow the previous one");

    // a wildcard symbol reads as zero
    a_wildcard_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (match_bits & ~care_bits) == '0)
        else $error("match bit set under a wildcard");

endmodule

bind range_to_ternary_chunk_encoder rtce_checker u_checker (.*);
